// ===== design/tif_pkg.sv =====
// Shared constants and types of the telnet IAC filter.
package tif_pkg;

    localparam logic [7:0] BYTE_IAC  = 8'hff;
    localparam logic [7:0] CMD_WILL  = 8'hfb;
    localparam logic [7:0] CMD_WONT  = 8'hfc;
    localparam logic [7:0] CMD_DO    = 8'hfd;
    localparam logic [7:0] CMD_DONT  = 8'hfe;
    localparam logic [7:0] BYTE_CR   = 8'd13;
    localparam logic [7:0] BYTE_LF   = 8'd10;
    localparam logic [7:0] BYTE_NUL  = 8'd0;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_ECHO  = 8'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       reply;
        logic [7:0] cmd;
        logic [7:0] data;
    } t_action;

endpackage

// ===== design/tif_front.sv =====
// Front parser: accepts network bytes and turns them into queued actions.
module tif_front import tif_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_action    o_action
);

    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_CMD      = 2'd1;
    localparam logic [1:0] MODE_OPT      = 2'd2;
    localparam logic [1:0] MODE_AFTER_CR = 2'd3;

    logic [1:0] r_mode;
    logic [1:0] n_mode;
    logic [7:0] r_pend;
    logic [7:0] n_pend;
    logic       accept;
    logic       want_push;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign o_push  = accept && want_push;

    always_comb begin
        n_mode    = r_mode;
        n_pend    = r_pend;
        want_push = 1'b0;
        o_action  = '{reply: 1'b0, cmd: CMD_WILL, data: i_rx_byte};
        case (r_mode)
            MODE_CMD: begin
                n_pend = i_rx_byte;
                n_mode = MODE_OPT;
            end
            MODE_OPT: begin
                n_mode = MODE_NORMAL;
                if ((r_pend == CMD_WILL || r_pend == CMD_DO) && i_rx_byte != OPT_SGA) begin
                    want_push = 1'b1;
                    o_action  = '{reply: 1'b1, cmd: CMD_DONT, data: i_rx_byte};
                end else if ((r_pend == CMD_WONT || r_pend == CMD_DONT)
                             && i_rx_byte == OPT_ECHO) begin
                    want_push = 1'b1;
                    o_action  = '{reply: 1'b1, cmd: CMD_WILL, data: OPT_ECHO};
                end
            end
            default: begin
                if (r_mode == MODE_AFTER_CR
                    && (i_rx_byte == BYTE_LF || i_rx_byte == BYTE_NUL)) begin
                    n_mode = MODE_NORMAL;
                end else if (i_rx_byte == BYTE_IAC) begin
                    n_mode = MODE_CMD;
                end else begin
                    n_mode    = (i_rx_byte == BYTE_CR) ? MODE_AFTER_CR : MODE_NORMAL;
                    want_push = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_pend <= 8'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
        end
    end

endmodule

// ===== design/tif_queue.sv =====
// Short action queue between the parser and the output sequencer.
module tif_queue import tif_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_action i_action,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_action o_action
);

    t_action                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr;
    logic [QUEUE_AW-1:0]    r_rd;
    logic [QUEUE_AW:0]      r_count;
    logic                   do_pop;

    assign o_full   = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_action = r_mem[r_rd];
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

// ===== design/tif_back.sv =====
// Output sequencer: expands queued actions into result items.
module tif_back import tif_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_action    i_action,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic       o_dest,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic [1:0] r_step;
    logic       r_valid;
    logic       r_dest;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic [7:0] w_byte;
    logic       w_last;

    assign load  = i_q_valid && (!r_valid || !i_stall);
    assign o_pop = load && w_last;

    always_comb begin
        w_byte = i_action.data;
        w_last = 1'b1;
        if (i_action.reply) begin
            case (r_step)
                2'd0: begin
                    w_byte = BYTE_IAC;
                    w_last = 1'b0;
                end
                2'd1: begin
                    w_byte = i_action.cmd;
                    w_last = 1'b0;
                end
                default: begin
                    w_byte = i_action.data;
                    w_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= w_last ? 2'd0 : r_step + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dest <= i_action.reply;
            r_byte <= w_byte;
            r_last <= w_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_dest     = r_dest;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

// ===== design/telnet_iac_filter.sv =====
// Top level of the receive-side telnet IAC filter.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_rx_byte
//   output    out        o_valid / i_stall    o_dest, o_out_byte, o_last
//
// One byte is accepted per cycle while the action queue has room.
// A plain byte passes through the action queue and the output register; a reply
// becomes three output bytes in the output sequencer; the four-entry queue absorbs it.
// Synchronous active-low reset returns the parser to normal mode and empties the queue.
// Output stalls back up into the queue and then stall the input.
module telnet_iac_filter import tif_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    output logic       o_dest,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    input  logic       i_stall
);

    logic    push;
    logic    full;
    logic    pop;
    logic    q_valid;
    t_action push_action;
    t_action head_action;

    tif_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .o_stall      (o_stall),
        .i_queue_full (full),
        .o_push       (push),
        .o_action     (push_action)
    );

    tif_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_action (push_action),
        .o_full   (full),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_action (head_action)
    );

    tif_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_action   (head_action),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_dest     (o_dest),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
